// ----- rtl/core/dbar_pkg.sv -----
// ---------------------------------------------------------------------------
// dbar_pkg
// types and constants shared by the door bus accessory responder
// ---------------------------------------------------------------------------
package dbar_pkg;

  localparam logic [15:0] AddrCommand   = 16'h9C41;
  localparam logic [15:0] AddrState     = 16'h9CB9;
  localparam logic [15:0] AddrBroadcast = 16'h9D31;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_HOST  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ILLEGAL  = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_REFUSED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KEY_NONE    = 3'd0,
    KEY_OPEN    = 3'd1,
    KEY_CLOSE   = 3'd2,
    KEY_IMPULSE = 3'd3,
    KEY_VENT    = 3'd4,
    KEY_HALF    = 3'd5,
    KEY_LAMP    = 3'd6
  } key_e;

  // host request codes
  localparam logic [3:0] ReqOpen    = 4'd0;
  localparam logic [3:0] ReqClose   = 4'd1;
  localparam logic [3:0] ReqImpulse = 4'd2;
  localparam logic [3:0] ReqVent    = 4'd3;
  localparam logic [3:0] ReqHalf    = 4'd4;
  localparam logic [3:0] ReqLamp    = 4'd5;
  localparam logic [3:0] ReqStop    = 4'd6;
  localparam logic [3:0] ReqTarget  = 4'd7;
  localparam logic [3:0] ReqCancel  = 4'd8;

  localparam logic [3:0] DsUnknown  = 4'd0;
  localparam logic [3:0] DsStopped  = 4'd1;
  localparam logic [3:0] DsOpening  = 4'd2;
  localparam logic [3:0] DsClosing  = 4'd3;
  localparam logic [3:0] DsMoveHalf = 4'd4;
  localparam logic [3:0] DsMoveVent = 4'd5;
  localparam logic [3:0] DsVent     = 4'd6;
  localparam logic [3:0] DsOpen     = 4'd7;
  localparam logic [3:0] DsClosed   = 4'd8;
  localparam logic [3:0] DsHalfOpen = 4'd9;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EXEC = 2'd1,
    FSM_EMIT = 2'd2
  } fsm_e;

  // command from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       emit;
    logic       last;
  } dbar_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic [6:0] count;
  } dbar_sts_t;

  // key word table: pressed word 1, released word 1, pressed word 2, released word 2
  function automatic logic [15:0] key_word(input logic [2:0] k, input logic [1:0] sel);
    logic [15:0] w;
    w = 16'h0000;
    case (k)
      KEY_OPEN:    w = (sel == 2'd0) ? 16'h0210 : (sel == 2'd1) ? 16'h0110 : 16'h0000;
      KEY_CLOSE:   w = (sel == 2'd0) ? 16'h0220 : (sel == 2'd1) ? 16'h0120 : 16'h0000;
      KEY_IMPULSE: w = (sel == 2'd0) ? 16'h0240 : (sel == 2'd1) ? 16'h0140 : 16'h0000;
      KEY_VENT:    w = (sel == 2'd0) ? 16'h0200 : (sel == 2'd1) ? 16'h0100 : 16'h4000;
      KEY_HALF:    w = (sel == 2'd0) ? 16'h0200 : (sel == 2'd1) ? 16'h0100 : 16'h0400;
      KEY_LAMP:    w = (sel == 2'd0) ? 16'h0100 : (sel == 2'd1) ? 16'h0800 : 16'h0200;
      default:     w = 16'h0000;
    endcase
    return w;
  endfunction

  function automatic logic door_in_motion(input logic [3:0] s);
    return (s >= DsOpening) && (s <= DsMoveVent);
  endfunction

endpackage

// ----- rtl/core/dbar_ctrl.sv -----
// ---------------------------------------------------------------------------
// dbar_ctrl
// sequencer: accepts an item, runs its update, then emits its results
// ---------------------------------------------------------------------------
module dbar_ctrl import dbar_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dbar_cmd_t cmd_o,
  input  dbar_sts_t sts_i
);

  fsm_e       state_q, state_d;
  logic [6:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.last  = (idx_q + 7'd1 >= sts_i.count);
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        cmd_o.exec = 1'b1;
        idx_d      = '0;
        state_d    = FSM_EMIT;
      end
      FSM_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit = 1'b1;
          idx_d      = idx_q + 7'd1;
          if (cmd_o.last) state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while emitting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == FSM_EXEC) else $error("load without exec");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_EXEC |=> idx_q == 7'd0) else $error("index not cleared");

endmodule

// ----- rtl/core/dbar_datapath.sv -----
// ---------------------------------------------------------------------------
// dbar_datapath
// door, link, key and lamp state with the per-item update and read words
// ---------------------------------------------------------------------------
module dbar_datapath import dbar_pkg::*; #(
  parameter int MaxReadWords = 64,
  parameter int MaxToggles   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dbar_cmd_t   cmd_i,
  output dbar_sts_t   sts_o,
  input  logic [15:0] in_data_i [5],
  input  logic [6:0]  reg_count_i,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  request_i,
  input  logic [15:0] timeout_i,
  input  logic [15:0] hold_i,
  output logic [15:0] out_word_o,
  output logic [1:0]  status_o,
  output logic [3:0]  door_state_o,
  output logic [7:0]  door_position_o,
  output logic        lamp_on_o,
  output logic        lamp_known_o,
  output logic        connected_o,
  output logic [2:0]  toggles_waiting_o
);

  localparam logic [6:0] MaxRd = 7'(MaxReadWords);
  localparam logic [2:0] MaxTg = 3'(MaxToggles);

  typedef struct packed {
    logic        link_up;
    logic [15:0] since_response;
    logic [2:0]  pending_key;
    logic        key_presented;
    logic [15:0] since_press;
    logic [15:0] since_queued;
    logic [15:0] last_command_word;
    logic [15:0] last_state_word;
    logic [3:0]  door_code;
    logic [7:0]  raw_position;
    logic [7:0]  target_pos;
    logic        target_opening;
    logic        target_moving;
    logic [15:0] since_target;
    logic        lamp_bit;
    logic        lamp_fresh;
    logic [2:0]  toggle_count;
    logic [15:0] since_release;
  } st_t;

  st_t st_q, st_d;

  // latched item
  logic [1:0]  mode_q;
  logic [15:0] addr_q, wf_q, ws_q, wl_q;
  logic [6:0]  n_q;
  logic [3:0]  req_q;
  logic [7:0]  tgt_q;
  logic [1:0]  status_q, status_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [15:0] w0_q, w1_q, w2_q, w3_q, w4_q;
  logic [15:0] w0_d, w1_d, w2_d, w3_d, w4_d;
  logic [6:0]  idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      addr_q <= in_data_i[0];
      wf_q   <= in_data_i[1];
      ws_q   <= in_data_i[2];
      wl_q   <= in_data_i[3];
      tgt_q  <= in_data_i[4][7:0];
      n_q    <= reg_count_i;
      req_q  <= request_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      w0_q <= w0_d; w1_q <= w1_d; w2_q <= w2_d; w3_q <= w3_d; w4_q <= w4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      cnt_q <= 7'd1;
      idx_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
        idx_q <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + 7'd1;
      end
    end
  end

  function automatic logic [15:0] sat(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] cur_pos(input st_t s);
    if (s.door_code == DsClosed) return 8'd0;
    if (s.door_code == DsOpen) return 8'd200;
    return s.raw_position;
  endfunction

  function automatic logic unsent(input st_t s);
    return (s.pending_key == KEY_LAMP) && !s.key_presented;
  endfunction

  function automatic st_t clr_tgt(input st_t s);
    st_t r;
    r = s;
    r.target_pos = '0;
    r.target_moving = 1'b0;
    return r;
  endfunction

  function automatic st_t settled(input st_t s);
    st_t r;
    r = s;
    if (r.toggle_count != 0) begin
      r.toggle_count = r.toggle_count - 3'd1;
      if (r.toggle_count == {2'b0, unsent(r)}) r.since_release = '0;
    end
    return r;
  endfunction

  function automatic st_t forget(input st_t s);
    st_t r;
    r = s;
    r.since_release = '0;
    r.toggle_count = {2'b0, unsent(r)};
    return r;
  endfunction

  function automatic st_t drop_cmd(input st_t s);
    st_t  r;
    logic was;
    r = s;
    was = r.pending_key == KEY_LAMP;
    r.pending_key = KEY_NONE;
    r.key_presented = 1'b0;
    r.since_press = '0;
    if (was) r = settled(r);
    else r = clr_tgt(r);
    return r;
  endfunction

  function automatic st_t queue(input st_t s, input logic [2:0] k, output logic ok);
    st_t r;
    r = s;
    ok = 1'b0;
    if (r.link_up && r.pending_key == KEY_NONE) begin
      if (k != KEY_LAMP) r = clr_tgt(r);
      r.pending_key = k;
      r.key_presented = 1'b0;
      r.since_press = '0;
      r.since_queued = '0;
      ok = 1'b1;
    end
    return r;
  endfunction

  function automatic st_t stop(input st_t s, output logic ok);
    st_t r;
    if (!door_in_motion(s.door_code)) begin
      r = clr_tgt(s);
      ok = 1'b1;
    end else begin
      r = queue(s, KEY_IMPULSE, ok);
    end
    return r;
  endfunction

  function automatic st_t set_door(input st_t s, input logic [3:0] c);
    st_t r;
    r = s;
    if (r.door_code != c) begin
      r.door_code = c;
      if (r.target_pos != 0) begin
        if (c == (r.target_opening ? DsOpening : DsClosing)) r.target_moving = 1'b1;
        else if (r.target_moving && !door_in_motion(c)) r = clr_tgt(r);
      end
    end
    return r;
  endfunction

  always_comb begin
    st_t         s;
    logic        ok, okq, reached, opening;
    logic [7:0]  p, cur;
    logic [15:0] cw0, cw1;
    logic [2:0]  k;
    s = st_q;
    ok = 1'b0; okq = 1'b0; reached = 1'b0; opening = 1'b0;
    p = '0; cur = '0; cw0 = '0; cw1 = '0; k = '0;
    status_d = ST_OK;
    cnt_d = 7'd1;
    w0_d = '0; w1_d = '0; w2_d = '0; w3_d = '0; w4_d = '0;
    case (mode_q)
      MODE_TICK: begin
        s.since_response = sat(s.since_response);
        s.since_press    = sat(s.since_press);
        s.since_queued   = sat(s.since_queued);
        s.since_target   = sat(s.since_target);
        if (s.since_release != 0) s.since_release = sat(s.since_release);
        if (s.link_up && s.since_response > timeout_i) begin
          s.link_up = 1'b0;
          s = drop_cmd(s);
          s = clr_tgt(s);
          s = forget(s);
          s.lamp_fresh = 1'b0;
        end
        if (s.pending_key != KEY_NONE && s.since_queued > timeout_i) s = drop_cmd(s);
        if (s.target_pos != 0 && !s.target_moving && s.since_target > timeout_i)
          s = clr_tgt(s);
        if (s.since_release != 0 && (s.since_release - 16'd1) > timeout_i) s = forget(s);
      end
      MODE_HOST: begin
        case (req_q)
          ReqOpen:    s = queue(s, KEY_OPEN, ok);
          ReqClose:   s = queue(s, KEY_CLOSE, ok);
          ReqImpulse: s = queue(s, KEY_IMPULSE, ok);
          ReqVent:    s = queue(s, KEY_VENT, ok);
          ReqHalf:    s = queue(s, KEY_HALF, ok);
          ReqLamp: begin
            if (s.toggle_count < MaxTg) begin
              s = queue(s, KEY_LAMP, ok);
              if (ok) s.toggle_count = s.toggle_count + 3'd1;
            end
          end
          ReqStop: s = stop(s, ok);
          ReqTarget: begin
            if (tgt_q <= 8'd10) s = queue(s, KEY_CLOSE, ok);
            else if (tgt_q >= 8'd190) s = queue(s, KEY_OPEN, ok);
            else begin
              cur = cur_pos(s);
              if (tgt_q == cur) s = stop(s, ok);
              else begin
                opening = tgt_q > cur;
                s = queue(s, opening ? KEY_OPEN : KEY_CLOSE, ok);
                if (ok) begin
                  s.target_pos = tgt_q;
                  s.since_target = '0;
                  s.target_opening = opening;
                  s.target_moving = s.door_code == (opening ? DsOpening : DsClosing);
                end
              end
            end
          end
          ReqCancel: begin
            if (s.pending_key == KEY_LAMP && !s.key_presented) begin
              s = drop_cmd(s);
              ok = 1'b1;
            end
          end
          default: ok = 1'b0;
        endcase
        status_d = ok ? ST_ACCEPTED : ST_REFUSED;
      end
      MODE_WRITE: begin
        if (addr_q == AddrCommand) begin
          s.since_response = '0;
          s.link_up = 1'b1;
          if (n_q >= 7'd1) s.last_command_word = wf_q;
        end else if (addr_q == AddrBroadcast) begin
          s.since_response = '0;
          s.link_up = 1'b1;
          if (n_q > 7'd2 && s.last_state_word != ws_q) begin
            s.last_state_word = ws_q;
            case (ws_q[15:8])
              8'h00: s = set_door(s, (ws_q[7:0] == 8'h61) ? DsVent : DsStopped);
              8'h01: s = set_door(s, DsOpening);
              8'h02: s = set_door(s, DsClosing);
              8'h05: s = set_door(s, DsMoveHalf);
              8'h09: s = set_door(s, DsMoveVent);
              8'h0A: s = set_door(s, DsVent);
              8'h20: s = set_door(s, DsOpen);
              8'h40: s = set_door(s, DsClosed);
              8'h80: s = set_door(s, DsHalfOpen);
              default: s = s;
            endcase
          end
          if (n_q > 7'd1) begin
            p = wf_q[7:0];
            if (s.raw_position != p) begin
              s.raw_position = p;
              if (s.target_pos != 0 && s.target_moving) begin
                cur = cur_pos(s);
                reached = s.target_opening ? (cur >= s.target_pos) : (cur <= s.target_pos);
                if (reached) s = stop(s, okq);
              end
            end
          end
          if (n_q > 7'd6) begin
            s.lamp_fresh = 1'b1;
            if (s.lamp_bit != wl_q[4]) begin
              s.lamp_bit = wl_q[4];
              if (s.toggle_count > {2'b0, unsent(s)}) s = settled(s);
            end
          end else begin
            s.lamp_fresh = 1'b0;
          end
        end else begin
          status_d = ST_ILLEGAL;
        end
      end
      default: begin
        if (addr_q != AddrState) begin
          status_d = ST_ILLEGAL;
        end else begin
          s.since_response = '0;
          s.link_up = 1'b1;
          cnt_d = (n_q > MaxRd) ? MaxRd : n_q;
          if (cnt_d == 7'd8) begin
            k = s.pending_key;
            if (k != KEY_NONE && k <= KEY_LAMP) begin
              if (!s.key_presented) begin
                s.key_presented = 1'b1;
                s.since_press = '0;
                cw0 = key_word(k, 2'd0);
                cw1 = key_word(k, 2'd2);
              end else if (s.since_press > hold_i) begin
                s.key_presented = 1'b0;
                s.since_press = '0;
                s.pending_key = KEY_NONE;
                if (k == KEY_LAMP && s.toggle_count != 0) s.since_release = 16'd1;
                cw0 = key_word(k, 2'd1);
                cw1 = key_word(k, 2'd3);
              end
            end
            w0_d = {s.last_command_word[15:8], 8'h00};
            w1_d = {s.last_command_word[7:0], 8'h01};
            w2_d = cw0;
            w3_d = cw1;
          end else if (cnt_d == 7'd2) begin
            w0_d = {s.last_command_word[15:8], 8'h04};
            w1_d = {s.last_command_word[7:0], 8'h00};
          end else if (cnt_d == 7'd5) begin
            w0_d = {s.last_command_word[15:8], 8'h00};
            w1_d = {s.last_command_word[7:0], 8'h05};
            w2_d = 16'h0430;
            w3_d = 16'h10FF;
            w4_d = 16'hA845;
          end
          if (cnt_d == 7'd0) cnt_d = 7'd1;
        end
      end
    endcase
    st_d = s;
  end

  assign sts_o.count = cnt_q;

  always_comb begin
    case (idx_q)
      7'd0: out_word_o = w0_q;
      7'd1: out_word_o = w1_q;
      7'd2: out_word_o = w2_q;
      7'd3: out_word_o = w3_q;
      7'd4: out_word_o = w4_q;
      default: out_word_o = 16'h0000;
    endcase
  end

  logic [7:0] pos;
  assign pos               = cur_pos(st_q);
  assign status_o          = status_q;
  assign door_state_o      = st_q.door_code;
  assign door_position_o   = (pos > 8'd200) ? 8'd200 : pos;
  assign lamp_on_o         = st_q.lamp_bit;
  assign lamp_known_o      = st_q.lamp_fresh;
  assign connected_o       = st_q.link_up;
  assign toggles_waiting_o = st_q.toggle_count;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.toggle_count <= MaxTg) else $error("toggle count over cap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 7'd0 && cnt_q <= MaxRd) else $error("bad result count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.link_up |-> st_q.pending_key == KEY_NONE || $past(st_q.link_up))
    else $error("key pending without link");

endmodule

// ----- rtl/core/door_bus_accessory_responder.sv -----
// ---------------------------------------------------------------------------
// door_bus_accessory_responder
// garage door bus accessory responder top level
// ---------------------------------------------------------------------------
// Items enter on the s_axis channel: tick, bus write, bus read or host
// request. Each item is taken, updated in the next cycle, then its results
// leave on m_axis one word per cycle while m_axis_tready is high, tlast on
// the final one. A tick, write or host item gives one result.
// A read of the state block gives up to MaxReadWords results.
// The rate is set by the result sequencer, one transfer per cycle while m_axis_tready is high.
// No new item is taken until the last result of the current one is taken;
// when m_axis_tready is low the result holds and the sequencer waits.
// After reset the door, link, key and lamp state is clear, link down, timeout 2000 and hold 500.
// The APB port sets link_timeout_ms (0x0) and press_hold_ms (0x4).
// ---------------------------------------------------------------------------
module door_bus_accessory_responder import dbar_pkg::*; #(
  parameter int MaxReadWords = 64,
  parameter int MaxToggles   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address, reg_count, word_first, word_state, word_lamp, request, target
  input  logic [87:0] s_axis_tdata,
  // mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_word, door_state, door_position, lamp_on, lamp_known, connected,
  // toggles_waiting
  output logic [39:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dbar_cmd_t   cmd;
  dbar_sts_t   sts;
  logic [15:0] timeout_q, hold_q;
  logic [15:0] fields [5];
  logic [15:0] ow;
  logic [3:0]  ds;
  logic [7:0]  dp;
  logic        lo, lk, cn;
  logic [2:0]  tw;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'd2000;
      hold_q    <= 16'd500;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) timeout_q <= pwdata[15:0];
      else if (paddr == 3'd4) hold_q <= pwdata[15:0];
    end
  end

  always_comb begin
    case (paddr)
      3'd0:    prdata = {16'h0, timeout_q};
      3'd4:    prdata = {16'h0, hold_q};
      default: prdata = 32'h0;
    endcase
  end

  assign fields[0] = s_axis_tdata[15:0];
  assign fields[1] = s_axis_tdata[38:23];
  assign fields[2] = s_axis_tdata[54:39];
  assign fields[3] = s_axis_tdata[70:55];
  assign fields[4] = {8'h00, s_axis_tdata[82:75]};

  dbar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dbar_datapath #(
    .MaxReadWords (MaxReadWords),
    .MaxToggles   (MaxToggles)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_data_i         (fields),
    .reg_count_i       (s_axis_tdata[22:16]),
    .mode_i            (s_axis_tuser),
    .request_i         (s_axis_tdata[74:71]),
    .timeout_i         (timeout_q),
    .hold_i            (hold_q),
    .out_word_o        (ow),
    .status_o          (m_axis_tuser),
    .door_state_o      (ds),
    .door_position_o   (dp),
    .lamp_on_o         (lo),
    .lamp_known_o      (lk),
    .connected_o       (cn),
    .toggles_waiting_o (tw)
  );

  assign m_axis_tlast = cmd.last;
  assign m_axis_tdata = {6'b0, tw, cn, lk, lo, dp, ds, ow};

endmodule

// ----- tb/door_bus_accessory_responder_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// door_bus_accessory_responder_test
// Self-checking testbench for the door bus accessory responder. Directed
// bus reads, writes, broadcasts and host requests come first. Random traffic
// then runs under several register settings and idle patterns. A predictor
// kept in the bench computes the answer words and the status snapshot of
// every item, and each result transfer is compared field by field.
// ---------------------------------------------------------------------------
module door_bus_accessory_responder_test;
  import dbar_pkg::*;

  localparam int MaxWords = 64;
  localparam int MaxTog   = 4;
  localparam logic [2:0] RegTimeout = 3'h0;
  localparam logic [2:0] RegHold    = 3'h4;

  typedef struct {
    logic [15:0] word;
    logic        last;
    status_e     st;
    logic [3:0]  ds;
    logic [7:0]  pos;
    logic        lamp;
    logic        known;
    logic        conn;
    logic [2:0]  tog;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  door_bus_accessory_responder i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  answer_t     answers_due[$];
  int          errors;
  int          send_idle;
  int          recv_stall;

  // predicted block state
  logic [15:0] timeout_ms, hold_ms;
  logic        link_up, presented, tgt_open, tgt_moving, lamp_bit, lamp_fresh;
  key_e        pend_key;
  int unsigned t_resp, t_press, t_queued, t_target, t_release, toggles;
  logic [15:0] cmd_word, state_word;
  logic [3:0]  door;
  logic [7:0]  raw_pos, tgt_pos;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, exp_v);
    errors++;
  endtask

  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata, 0);
      end else begin
        a = answers_due.pop_front();
        if (m_axis_tdata[15:0] !== a.word) report_mismatch("out_word", m_axis_tdata[15:0], a.word);
        if (m_axis_tlast !== a.last) report_mismatch("last", m_axis_tlast, a.last);
        if (m_axis_tuser !== a.st) report_mismatch("status", m_axis_tuser, a.st);
        if (m_axis_tdata[19:16] !== a.ds) report_mismatch("door_state", m_axis_tdata[19:16], a.ds);
        if (m_axis_tdata[27:20] !== a.pos) report_mismatch("position", m_axis_tdata[27:20], a.pos);
        if (m_axis_tdata[28] !== a.lamp) report_mismatch("lamp_on", m_axis_tdata[28], a.lamp);
        if (m_axis_tdata[29] !== a.known) report_mismatch("lamp_known", m_axis_tdata[29], a.known);
        if (m_axis_tdata[30] !== a.conn) report_mismatch("connected", m_axis_tdata[30], a.conn);
        if (m_axis_tdata[33:31] !== a.tog) report_mismatch("toggles", m_axis_tdata[33:31], a.tog);
        if (m_axis_tdata[39:34] !== '0) report_mismatch("tdata pad", m_axis_tdata[39:34], 0);
      end
    end
  end

  // ---- door state predictor

  function automatic int unsigned bump(input int unsigned v);
    return (v < 65535) ? v + 1 : 65535;
  endfunction

  function automatic logic moving(input logic [3:0] s);
    return (s >= DsOpening) && (s <= DsMoveVent);
  endfunction

  function automatic int unsigned position_now();
    if (door == DsClosed) return 0;
    if (door == DsOpen) return 200;
    return raw_pos;
  endfunction

  function automatic int unsigned unsent_toggles();
    return (pend_key == KEY_LAMP && !presented) ? 1 : 0;
  endfunction

  function automatic void clear_target();
    tgt_pos = 0;
    tgt_moving = 1'b0;
  endfunction

  function automatic void toggle_settled();
    if (toggles == 0) return;
    toggles--;
    if (toggles == unsent_toggles()) t_release = 0;
  endfunction

  function automatic void forget_toggles();
    t_release = 0;
    toggles = unsent_toggles();
  endfunction

  function automatic void drop_key();
    logic was_lamp;
    was_lamp = (pend_key == KEY_LAMP);
    pend_key = KEY_NONE;
    presented = 1'b0;
    t_press = 0;
    if (was_lamp) toggle_settled();
    else clear_target();
  endfunction

  function automatic void link_down();
    if (!link_up) return;
    link_up = 1'b0;
    drop_key();
    clear_target();
    forget_toggles();
    lamp_fresh = 1'b0;
  endfunction

  function automatic void heard_from_bus();
    t_resp = 0;
    link_up = 1'b1;
  endfunction

  function automatic logic queue_press(input key_e k);
    if (!link_up || pend_key != KEY_NONE) return 1'b0;
    if (k != KEY_LAMP) clear_target();
    pend_key = k;
    presented = 1'b0;
    t_press = 0;
    t_queued = 0;
    return 1'b1;
  endfunction

  function automatic logic halt_door();
    if (!moving(door)) begin
      clear_target();
      return 1'b1;
    end
    return queue_press(KEY_IMPULSE);
  endfunction

  function automatic void new_door_state(input logic [3:0] s);
    if (door == s) return;
    door = s;
    if (tgt_pos == 0) return;
    if (s == (tgt_open ? DsOpening : DsClosing)) tgt_moving = 1'b1;
    else if (tgt_moving && !moving(s)) clear_target();
  endfunction

  function automatic void take_state_word(input logic [15:0] v);
    logic [15:0] prev;
    prev = state_word;
    state_word = v;
    if (prev == v) return;
    case (v[15:8])
      8'h00: new_door_state((v[7:0] == 8'h61) ? DsVent : DsStopped);
      8'h01: new_door_state(DsOpening);
      8'h02: new_door_state(DsClosing);
      8'h05: new_door_state(DsMoveHalf);
      8'h09: new_door_state(DsMoveVent);
      8'h0A: new_door_state(DsVent);
      8'h20: new_door_state(DsOpen);
      8'h40: new_door_state(DsClosed);
      8'h80: new_door_state(DsHalfOpen);
      default: ;
    endcase
  endfunction

  function automatic void take_position_word(input logic [15:0] v);
    logic hit;
    if (raw_pos == v[7:0]) return;
    raw_pos = v[7:0];
    if (tgt_pos == 0 || !tgt_moving) return;
    hit = tgt_open ? (position_now() >= tgt_pos) : (position_now() <= tgt_pos);
    if (hit) void'(halt_door());
  endfunction

  function automatic void take_lamp_word(input logic [15:0] v);
    lamp_fresh = 1'b1;
    if (lamp_bit == v[4]) return;
    lamp_bit = v[4];
    if (toggles <= unsent_toggles()) return;
    toggle_settled();
  endfunction

  // pressed word 1, released word 1, pressed word 2, released word 2
  function automatic logic [15:0] key_code(input key_e k, input int idx);
    logic [15:0] t [7][4];
    t = '{'{16'h0, 16'h0, 16'h0, 16'h0},
          '{16'h0210, 16'h0110, 16'h0, 16'h0},
          '{16'h0220, 16'h0120, 16'h0, 16'h0},
          '{16'h0240, 16'h0140, 16'h0, 16'h0},
          '{16'h0200, 16'h0100, 16'h4000, 16'h4000},
          '{16'h0200, 16'h0100, 16'h0400, 16'h0400},
          '{16'h0100, 16'h0800, 16'h0200, 16'h0200}};
    return t[int'(k)][idx];
  endfunction

  function automatic void key_words_for_read(output logic [15:0] w0, output logic [15:0] w1);
    key_e k;
    k = pend_key;
    w0 = 16'h0;
    w1 = 16'h0;
    if (k == KEY_NONE) return;
    if (!presented) begin
      presented = 1'b1;
      t_press = 0;
      w0 = key_code(k, 0);
      w1 = key_code(k, 2);
      return;
    end
    if (t_press <= hold_ms) return;
    presented = 1'b0;
    t_press = 0;
    pend_key = KEY_NONE;
    if (k == KEY_LAMP && toggles != 0) t_release = 1;
    w0 = key_code(k, 1);
    w1 = key_code(k, 3);
  endfunction

  function automatic void one_ms();
    t_resp = bump(t_resp);
    t_press = bump(t_press);
    t_queued = bump(t_queued);
    t_target = bump(t_target);
    if (t_release != 0) t_release = bump(t_release);
    if (link_up && t_resp > timeout_ms) link_down();
    if (pend_key != KEY_NONE && t_queued > timeout_ms) drop_key();
    if (tgt_pos != 0 && !tgt_moving && t_target > timeout_ms) clear_target();
    if (t_release != 0 && t_release - 1 > timeout_ms) forget_toggles();
  endfunction

  function automatic logic host_request(input logic [3:0] req, input logic [7:0] tgt);
    int unsigned cur;
    logic opening;
    case (req)
      ReqOpen:    return queue_press(KEY_OPEN);
      ReqClose:   return queue_press(KEY_CLOSE);
      ReqImpulse: return queue_press(KEY_IMPULSE);
      ReqVent:    return queue_press(KEY_VENT);
      ReqHalf:    return queue_press(KEY_HALF);
      ReqLamp: begin
        if (toggles >= MaxTog) return 1'b0;
        if (!queue_press(KEY_LAMP)) return 1'b0;
        toggles++;
        return 1'b1;
      end
      ReqStop: return halt_door();
      ReqTarget: begin
        if (tgt <= 10) return queue_press(KEY_CLOSE);
        if (tgt >= 190) return queue_press(KEY_OPEN);
        cur = position_now();
        if (tgt == cur) return halt_door();
        opening = (tgt > cur);
        if (!queue_press(opening ? KEY_OPEN : KEY_CLOSE)) return 1'b0;
        tgt_pos = tgt;
        t_target = 0;
        tgt_open = opening;
        tgt_moving = (door == (opening ? DsOpening : DsClosing));
        return 1'b1;
      end
      ReqCancel: begin
        if (pend_key != KEY_LAMP || presented) return 1'b0;
        drop_key();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void expect_answer(input logic [15:0] w, input logic last,
                                        input status_e st);
    answer_t a;
    int unsigned p;
    p = position_now();
    a.word = w;
    a.last = last;
    a.st = st;
    a.ds = door;
    a.pos = (p > 200) ? 8'd200 : p[7:0];
    a.lamp = lamp_bit;
    a.known = lamp_fresh;
    a.conn = link_up;
    a.tog = toggles[2:0];
    answers_due.insert(answers_due.size(), a);
  endfunction

  function automatic void predict_item(input mode_e m, input logic [15:0] addr,
      input logic [6:0] n, input logic [15:0] wf, input logic [15:0] ws,
      input logic [15:0] wl, input logic [3:0] req, input logic [7:0] tgt);
    logic [15:0] words [MaxWords];
    int cnt;
    if (m == MODE_TICK) begin
      one_ms();
      expect_answer(16'h0, 1'b1, ST_OK);
      return;
    end
    if (m == MODE_HOST) begin
      expect_answer(16'h0, 1'b1, host_request(req, tgt) ? ST_ACCEPTED : ST_REFUSED);
      return;
    end
    if (m == MODE_WRITE) begin
      if (addr == AddrCommand) begin
        heard_from_bus();
        if (n >= 1) cmd_word = wf;
      end else if (addr == AddrBroadcast) begin
        heard_from_bus();
        if (n > 2) take_state_word(ws);
        if (n > 1) take_position_word(wf);
        if (n > 6) take_lamp_word(wl);
        else lamp_fresh = 1'b0;
      end else begin
        expect_answer(16'h0, 1'b1, ST_ILLEGAL);
        return;
      end
      expect_answer(16'h0, 1'b1, ST_OK);
      return;
    end
    if (addr != AddrState) begin
      expect_answer(16'h0, 1'b1, ST_ILLEGAL);
      return;
    end
    heard_from_bus();
    cnt = (n > MaxWords) ? MaxWords : n;
    foreach (words[i]) words[i] = 16'h0;
    if (cnt == 8) begin
      words[0] = {cmd_word[15:8], 8'h00};
      words[1] = {cmd_word[7:0], 8'h01};
      key_words_for_read(words[2], words[3]);
    end else if (cnt == 2) begin
      words[0] = {cmd_word[15:8], 8'h04};
      words[1] = {cmd_word[7:0], 8'h00};
    end else if (cnt == 5) begin
      words[0] = {cmd_word[15:8], 8'h00};
      words[1] = {cmd_word[7:0], 8'h05};
      words[2] = 16'h0430;
      words[3] = 16'h10FF;
      words[4] = 16'hA845;
    end
    if (cnt == 0) begin
      expect_answer(16'h0, 1'b1, ST_OK);
      return;
    end
    for (int i = 0; i < cnt; i++) expect_answer(words[i], (i + 1 == cnt), ST_OK);
  endfunction

  // ---- drivers

  task automatic send_item(input mode_e m, input logic [15:0] addr, input logic [6:0] n,
      input logic [15:0] wf, input logic [15:0] ws, input logic [15:0] wl,
      input logic [3:0] req, input logic [7:0] tgt);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= m;
    s_axis_tdata <= {5'b0, tgt, req, wl, ws, wf, n, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(m, addr, n, wf, ws, wl, req, tgt);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegTimeout) timeout_ms = value;
    else hold_ms = value;
  endtask

  task automatic tick_item();
    send_item(MODE_TICK, 16'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic read_state(input logic [6:0] n);
    send_item(MODE_READ, AddrState, n, 16'($urandom), 16'($urandom), 16'($urandom),
              4'($urandom), 8'($urandom));
  endtask

  task automatic broadcast(input logic [6:0] n, input logic [15:0] wf,
                           input logic [15:0] ws, input logic [15:0] wl);
    send_item(MODE_WRITE, AddrBroadcast, n, wf, ws, wl, 4'($urandom), 8'($urandom));
  endtask

  task automatic host(input logic [3:0] req, input logic [7:0] tgt);
    send_item(MODE_HOST, 16'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), req, tgt);
  endtask

  task automatic random_item();
    int pick;
    logic [15:0] ws;
    logic [7:0] codes [10];
    codes = '{8'h00, 8'h01, 8'h02, 8'h05, 8'h09, 8'h0A, 8'h20, 8'h40, 8'h80, 8'h00};
    pick = $urandom_range(99);
    if (pick < 25) begin
      tick_item();
    end else if (pick < 45) begin
      case ($urandom_range(9))
        0: send_item(MODE_READ, 16'($urandom), 7'($urandom_range(64)), 16'($urandom),
                     16'($urandom), 16'($urandom), 4'($urandom), 8'($urandom));
        1: read_state(7'($urandom_range(64)));
        2: read_state(($urandom_range(1)) ? 7'd2 : 7'd5);
        default: read_state(7'd8);
      endcase
    end else if (pick < 70) begin
      case ($urandom_range(9))
        0: send_item(MODE_WRITE, 16'($urandom), 7'($urandom_range(64)), 16'($urandom),
                     16'($urandom), 16'($urandom), 4'($urandom), 8'($urandom));
        1, 2: send_item(MODE_WRITE, AddrCommand, 7'($urandom_range(64)), 16'($urandom),
                        16'($urandom), 16'($urandom), 4'($urandom), 8'($urandom));
        default: begin
          ws = {codes[$urandom_range(9)], ($urandom_range(3) == 0) ? 8'h61 : 8'($urandom)};
          if ($urandom_range(9) == 0) ws = 16'($urandom);
          broadcast(($urandom_range(4) == 0) ? 7'($urandom_range(64)) : 7'd9,
                    {8'($urandom), 8'($urandom_range(255))}, ws, 16'($urandom));
        end
      endcase
    end else begin
      host(4'($urandom_range(8)), 8'($urandom_range(200)));
    end
  endtask

  // ---- tests

  task automatic test_reads();
    read_state(7'd8);
    read_state(7'd2);
    read_state(7'd5);
    read_state(7'd0);
    read_state(7'd3);
    read_state(7'd64);
    read_state(7'd100);
    send_item(MODE_READ, 16'hFFFF, 7'd8, 16'h0, 16'h0, 16'h0, ReqOpen, 8'h0);
  endtask

  task automatic test_writes();
    send_item(MODE_WRITE, AddrCommand, 7'd1, 16'hFFFF, 16'h0, 16'h0, ReqOpen, 8'h0);
    send_item(MODE_WRITE, AddrCommand, 7'd0, 16'h1234, 16'h0, 16'h0, ReqOpen, 8'h0);
    send_item(MODE_WRITE, 16'h0000, 7'd9, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 8'hFF);
    broadcast(7'd9, 16'h00FF, 16'h0100, 16'h0010);
    broadcast(7'd9, 16'h0064, 16'h7700, 16'h0000);
    broadcast(7'd3, 16'h0000, 16'h0061, 16'h0010);
    broadcast(7'd9, 16'h00C8, 16'h2000, 16'hFFFF);
    read_state(7'd8);
  endtask

  task automatic test_requests();
    for (int r = 0; r <= 8; r++) begin
      host(4'(r), 8'd100);
      read_state(7'd8);
      read_state(7'd8);
    end
    host(4'd15, 8'd0);
    host(ReqTarget, 8'd200);
  endtask

  task automatic test_target_stop();
    broadcast(7'd9, 16'h0020, 16'h4000, 16'h0000);
    host(ReqTarget, 8'd120);
    read_state(7'd8);
    broadcast(7'd9, 16'h0050, 16'h0100, 16'h0000);
    broadcast(7'd9, 16'h0078, 16'h0100, 16'h0010);
    read_state(7'd8);
    host(ReqLamp, 8'd0);
    host(ReqCancel, 8'd0);
  endtask

  task automatic test_random(input int count, input int idle, input int stall,
                             input logic [15:0] tmo, input logic [15:0] hold);
    write_reg(RegTimeout, tmo);
    write_reg(RegHold, hold);
    send_idle = idle;
    recv_stall = stall;
    repeat (count) random_item();
  endtask

  initial begin
    errors = 0;
    send_idle = 0;
    recv_stall = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_TICK;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = RegTimeout;
    pwdata = '0;
    timeout_ms = 16'd2000;
    hold_ms = 16'd500;
    link_up = 0; presented = 0; tgt_open = 0; tgt_moving = 0;
    lamp_bit = 0; lamp_fresh = 0; pend_key = KEY_NONE;
    t_resp = 0; t_press = 0; t_queued = 0; t_target = 0; t_release = 0; toggles = 0;
    cmd_word = 0; state_word = 0; door = DsUnknown; raw_pos = 0; tgt_pos = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reads();
    test_writes();
    test_requests();
    test_target_stop();
    test_random(75, 0, 0, 16'd12, 16'd2);
    test_random(75, 70, 0, 16'd1, 16'd0);
    test_random(75, 0, 70, 16'd40, 16'd5);
    test_random(50, 32, 32, 16'hFFFF, 16'hFFFF);
    test_random(40, 0, 0, 16'd2000, 16'd500);
    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dbar_pkg.sv
rtl/core/dbar_ctrl.sv
rtl/core/dbar_datapath.sv
rtl/core/door_bus_accessory_responder.sv
tb/door_bus_accessory_responder_test.sv
